FILE: hdl/assert_macros.svh
// Assertion macros for the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/cva_pkg.sv
// Shared types and constants of the colour-space Viterbi add-compare-select block.
package cva_pkg;

  localparam int NSTATES         = 16;
  localparam int STATE_BITS      = 4;
  localparam int BASE_BITS       = 2;
  localparam int COST_BITS       = 16;
  localparam int OUT_METRIC_BITS = 32;
  localparam int BP_BITS         = NSTATES * STATE_BITS;
  localparam int METRIC_BITS_DEF = 32;

  typedef enum logic [1:0] {
    FUNC_LETTER = 2'd0,
    FUNC_COLOUR = 2'd1,
    FUNC_CLOSE  = 2'd2,
    FUNC_CONTIG = 2'd3
  } func_t;

  // Control of the emission accumulators for one beat.
  typedef struct packed {
    logic                 obs;
    logic                 colour;
    logic                 clear;
    logic [BASE_BITS-1:0] symbol;
  } emit_ctrl_t;

  // Control of the path metric update for one beat.
  typedef struct packed {
    logic close;
    logic contig;
  } acs_ctrl_t;

endpackage

FILE: hdl/cva_in_if.sv
// Input channel interface: observation and column control beats.
interface cva_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic [cva_pkg::BASE_BITS-1:0]     symbol;
  logic [cva_pkg::COST_BITS-1:0]     match_cost;
  logic [cva_pkg::COST_BITS-1:0]     mismatch_cost;

  modport source (output valid, output func, output symbol, output match_cost,
                  output mismatch_cost, input ready);
  modport sink (input valid, input func, input symbol, input match_cost,
                input mismatch_cost, output ready);
endinterface

FILE: hdl/cva_out_if.sv
// Result channel interface: backpointers and best state of a closed column.
interface cva_out_if;
  logic                                valid;
  logic                                ready;
  logic [cva_pkg::BP_BITS-1:0]         back_pointers;
  logic [cva_pkg::STATE_BITS-1:0]      best_state;
  logic [cva_pkg::OUT_METRIC_BITS-1:0] best_metric;
  logic                                first_column;

  modport source (output valid, output back_pointers, output best_state,
                  output best_metric, output first_column, input ready);
  modport sink (input valid, input back_pointers, input best_state,
                input best_metric, input first_column, output ready);
endinterface

FILE: hdl/colorspace_viterbi_acs_top.sv
// Top level of the sixteen-state colour-space Viterbi add-compare-select block.
// A column-close beat is held in the input register, passes the combinational
// add-compare-select and best-state tree; its result lands in the result register.
// Throughput: one beat per cycle, observations and closes alike, unless a close
// waits because the result register is full and not being taken.
// Reset (synchronous, active low) zeroes emission sums and path metrics, marks
// the next column as the first one and empties both pipeline registers.
module colorspace_viterbi_acs_top #(
  parameter int METRIC_BITS = cva_pkg::METRIC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  cva_in_if.sink    in_bus,
  cva_out_if.source out_bus
);

  // Input register stage. Every accepted beat lands here first.
  logic                              s1_valid_r;
  cva_pkg::func_t                    s1_func_r;
  logic [cva_pkg::BASE_BITS-1:0]     s1_symbol_r;
  logic [cva_pkg::COST_BITS-1:0]     s1_match_r;
  logic [cva_pkg::COST_BITS-1:0]     s1_mismatch_r;

  // Result register stage.
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic [cva_pkg::BP_BITS-1:0]         out_bp_r;
  logic [cva_pkg::STATE_BITS-1:0]      out_best_state_r;
  logic [cva_pkg::OUT_METRIC_BITS-1:0] out_best_metric_r;
  logic                                out_first_r;

  logic                 s1_is_close;
  logic                 advance;
  logic                 out_load;
  cva_pkg::emit_ctrl_t  emit_ctrl;
  cva_pkg::acs_ctrl_t   acs_ctrl;

  logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0] emission;
  logic [cva_pkg::BP_BITS-1:0]                  acs_bp;
  logic [cva_pkg::STATE_BITS-1:0]               acs_best_state;
  logic [METRIC_BITS-1:0]                       acs_best_metric;
  logic                                         acs_first;
  logic [cva_pkg::OUT_METRIC_BITS-1:0]          best_metric_clip;

  // Observation and contig beats produce no result, so they always leave the
  // input register. A close only waits when the result register is still full
  // and its beat is not being taken this cycle.
  assign s1_is_close = (s1_func_r == cva_pkg::FUNC_CLOSE);
  assign advance     = s1_valid_r && (!s1_is_close || !out_valid_r || out_bus.ready);
  assign out_load    = advance && s1_is_close;
  assign in_bus.ready = !s1_valid_r || advance;

  // Decode the function code into the two state-update controls.
  always_comb begin
    emit_ctrl        = '0;
    acs_ctrl         = '0;
    emit_ctrl.symbol = s1_symbol_r;
    case (s1_func_r)
      cva_pkg::FUNC_LETTER: begin
        emit_ctrl.obs = advance;
      end
      cva_pkg::FUNC_COLOUR: begin
        emit_ctrl.obs    = advance;
        emit_ctrl.colour = 1'b1;
      end
      cva_pkg::FUNC_CLOSE: begin
        emit_ctrl.clear = advance;
        acs_ctrl.close  = advance;
      end
      cva_pkg::FUNC_CONTIG: begin
        emit_ctrl.clear = advance;
        acs_ctrl.contig = advance;
      end
      default: begin
        emit_ctrl.obs = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_func_r     <= cva_pkg::func_t'(in_bus.func);
      s1_symbol_r   <= in_bus.symbol;
      s1_match_r    <= in_bus.match_cost;
      s1_mismatch_r <= in_bus.mismatch_cost;
    end
  end

  cva_emit #(
    .METRIC_BITS (METRIC_BITS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (emit_ctrl),
    .match_cost    (s1_match_r),
    .mismatch_cost (s1_mismatch_r),
    .emission      (emission)
  );

  cva_acs #(
    .METRIC_BITS (METRIC_BITS)
  ) u_acs (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (acs_ctrl),
    .emission      (emission),
    .back_pointers (acs_bp),
    .best_state    (acs_best_state),
    .best_metric   (acs_best_metric),
    .first_column  (acs_first)
  );

  // The reported metric is 32 bits wide. Wider internal metrics saturate to
  // all ones; narrower ones are zero-extended.
  always_comb begin
    if ((METRIC_BITS > cva_pkg::OUT_METRIC_BITS) &&
        (|(acs_best_metric >> cva_pkg::OUT_METRIC_BITS))) begin
      best_metric_clip = '1;
    end else begin
      best_metric_clip = cva_pkg::OUT_METRIC_BITS'(acs_best_metric);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bp_r          <= acs_bp;
      out_best_state_r  <= acs_best_state;
      out_best_metric_r <= best_metric_clip;
      out_first_r       <= acs_first;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.back_pointers = out_bp_r;
  assign out_bus.best_state    = out_best_state_r;
  assign out_bus.best_metric   = out_best_metric_r;
  assign out_bus.first_column  = out_first_r;

endmodule

FILE: hdl/cva_emit.sv
// Per-state emission cost accumulators with saturation.
module cva_emit #(
  parameter int METRIC_BITS = cva_pkg::METRIC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  cva_pkg::emit_ctrl_t                         ctrl,
  input  logic [cva_pkg::COST_BITS-1:0]               match_cost,
  input  logic [cva_pkg::COST_BITS-1:0]               mismatch_cost,
  output logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0] emission
);

  logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0] emission_r;
  logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0] emission_nxt;

  always_comb begin
    logic [cva_pkg::BASE_BITS-1:0] key;
    logic [cva_pkg::BASE_BITS-1:0] left_b;
    logic [cva_pkg::BASE_BITS-1:0] right_b;
    logic [cva_pkg::COST_BITS-1:0] cost;
    logic [METRIC_BITS:0]          sum;
    emission_nxt = emission_r;
    for (int j = 0; j < cva_pkg::NSTATES; j++) begin
      left_b  = cva_pkg::BASE_BITS'(j >> cva_pkg::BASE_BITS);
      right_b = cva_pkg::BASE_BITS'(j);
      key     = ctrl.colour ? (left_b ^ right_b) : left_b;
      cost    = (key == ctrl.symbol) ? match_cost : mismatch_cost;
      sum     = (METRIC_BITS+1)'(emission_r[j]) + (METRIC_BITS+1)'(cost);
      if (ctrl.clear) begin
        emission_nxt[j] = '0;
      end else if (ctrl.obs) begin
        emission_nxt[j] = sum[METRIC_BITS] ? '1 : sum[METRIC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emission_r <= '0;
    end else begin
      emission_r <= emission_nxt;
    end
  end

  assign emission = emission_r;

endmodule

FILE: hdl/cva_acs.sv
// Path metrics with add-compare-select and best-state search for a column close.
module cva_acs #(
  parameter int METRIC_BITS = cva_pkg::METRIC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  cva_pkg::acs_ctrl_t                          ctrl,
  input  logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0] emission,
  output logic [cva_pkg::BP_BITS-1:0]                 back_pointers,
  output logic [cva_pkg::STATE_BITS-1:0]              best_state,
  output logic [METRIC_BITS-1:0]                      best_metric,
  output logic                                        first_column
);

  localparam int NGROUPS = 4;

  logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0] path_metric_r;
  logic                                         first_r;

  logic [NGROUPS-1:0][METRIC_BITS-1:0]          grp_m;
  logic [NGROUPS-1:0][1:0]                      grp_sel;
  logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0] new_m;

  // Predecessors of a state with left base g are the states whose right base is g:
  // g, g+4, g+8, g+12. A two-level tree keeps ties at the lowest index.
  always_comb begin
    logic [METRIC_BITS-1:0] m_a;
    logic [METRIC_BITS-1:0] m_b;
    logic [1:0]             s_a;
    logic [1:0]             s_b;
    for (int g = 0; g < NGROUPS; g++) begin
      if (path_metric_r[g+4] < path_metric_r[g]) begin
        m_a = path_metric_r[g+4];
        s_a = 2'd1;
      end else begin
        m_a = path_metric_r[g];
        s_a = 2'd0;
      end
      if (path_metric_r[g+12] < path_metric_r[g+8]) begin
        m_b = path_metric_r[g+12];
        s_b = 2'd3;
      end else begin
        m_b = path_metric_r[g+8];
        s_b = 2'd2;
      end
      if (m_b < m_a) begin
        grp_m[g]   = m_b;
        grp_sel[g] = s_b;
      end else begin
        grp_m[g]   = m_a;
        grp_sel[g] = s_a;
      end
    end
  end

  always_comb begin
    logic [METRIC_BITS:0] sum;
    logic [1:0]           grp;
    back_pointers = '0;
    for (int j = 0; j < cva_pkg::NSTATES; j++) begin
      grp = 2'(j >> 2);
      sum = (METRIC_BITS+1)'(emission[j]) + (METRIC_BITS+1)'(grp_m[grp]);
      if (first_r) begin
        new_m[j] = emission[j];
      end else begin
        new_m[j] = sum[METRIC_BITS] ? '1 : sum[METRIC_BITS-1:0];
        back_pointers[cva_pkg::STATE_BITS*j +: cva_pkg::STATE_BITS] = {grp_sel[grp], grp};
      end
    end
  end

  // Minimum over the sixteen new metrics by a pairwise tree, lower index wins ties.
  always_comb begin
    logic [cva_pkg::NSTATES-1:0][METRIC_BITS-1:0]         t_m;
    logic [cva_pkg::NSTATES-1:0][cva_pkg::STATE_BITS-1:0] t_i;
    t_m = new_m;
    for (int j = 0; j < cva_pkg::NSTATES; j++) begin
      t_i[j] = cva_pkg::STATE_BITS'(j);
    end
    for (int w = cva_pkg::NSTATES / 2; w >= 1; w = w >> 1) begin
      for (int e = 0; e < w; e++) begin
        if (t_m[2*e+1] < t_m[2*e]) begin
          t_m[e] = t_m[2*e+1];
          t_i[e] = t_i[2*e+1];
        end else begin
          t_m[e] = t_m[2*e];
          t_i[e] = t_i[2*e];
        end
      end
    end
    best_metric = t_m[0];
    best_state  = t_i[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_metric_r <= '0;
      first_r       <= 1'b1;
    end else if (ctrl.close) begin
      path_metric_r <= new_m;
      first_r       <= 1'b0;
    end else if (ctrl.contig) begin
      path_metric_r <= '0;
      first_r       <= 1'b1;
    end
  end

  assign first_column = first_r;

endmodule

FILE: hdl/cva_checker.sv
// Port-level assertion checker for the colour-space Viterbi block and its bind.
`include "assert_macros.svh"

module cva_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cva_pkg::BP_BITS-1:0]         back_pointers,
  input logic [cva_pkg::STATE_BITS-1:0]      best_state,
  input logic [cva_pkg::OUT_METRIC_BITS-1:0] best_metric,
  input logic                                first_column
);

  `ASSERT_ALWAYS(a_reset_empties_output, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_CLK(a_ready_low_only_when_stuck, !in_ready |-> out_valid && !out_ready, "input stalled without a stuck result")
  `ASSERT_CLK(a_first_column_no_bp, out_valid && first_column |-> back_pointers == '0, "first column carries backpointers")
  `ASSERT_CLK(a_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_payload_holds, out_valid && !out_ready |=> $stable(best_state) && $stable(best_metric), "result changed while stalled")

endmodule

bind colorspace_viterbi_acs_top cva_checker u_cva_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .back_pointers (out_bus.back_pointers),
  .best_state    (out_bus.best_state),
  .best_metric   (out_bus.best_metric),
  .first_column  (out_bus.first_column)
);

FILE: test/colorspace_viterbi_acs_top_test.sv
// Self-checking testbench of the colour-space Viterbi add-compare-select block.
`timescale 1ns / 100ps

module colorspace_viterbi_acs_top_test;
  import cva_pkg::*;

  // The block is built with its default metric width, and the predictor follows it.
  localparam int METRIC_W = METRIC_BITS_DEF;
  // Cycles without any beat on either channel before the run is declared hung.
  // The slowest correct stretch is a random input gap, an output stall and the
  // pass through the pipeline, so this leaves a wide margin.
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1500;
  // Observations at full match cost in one long column, enough for large metrics.
  localparam int LONG_OBS = 200;

  typedef logic [METRIC_W-1:0] metric_t;

  // One expected column result, laid out like the result channel.
  typedef struct packed {
    logic [BP_BITS-1:0]         back_pointers;
    logic [STATE_BITS-1:0]      best_state;
    logic [OUT_METRIC_BITS-1:0] best_metric;
    logic                       first_column;
  } column_result_t;

  logic clk;
  logic rst_n;

  cva_in_if  in_bus ();
  cva_out_if out_bus ();

  colorspace_viterbi_acs_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Predictor state: per-state emission sums of the open column, path metrics
  // of the last closed column, and whether the next close starts a contig.
  metric_t emission_acc [NSTATES];
  metric_t path_acc [NSTATES];
  bit      column_is_first;

  column_result_t expected_columns [$];

  int  beats_sent;
  int  columns_checked;
  int  mismatch_count;
  int  saturated_columns;
  bit  idle_enable;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic metric_t sat_add(metric_t a, metric_t b);
    logic [METRIC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[METRIC_W] ? '1 : s[METRIC_W-1:0];
  endfunction

  // Advances the predictor by one accepted beat and queues the column result
  // that a close produces.
  task automatic predict_beat(func_t f, logic [1:0] sym, logic [15:0] mc, logic [15:0] xc);
    metric_t        newm [NSTATES];
    logic [63:0]    bp;
    logic [63:0]    wide;
    logic [1:0]     key;
    int             pick;
    int             best;
    column_result_t res;
    bp = '0;
    case (f)
      FUNC_LETTER, FUNC_COLOUR: begin
        for (int j = 0; j < NSTATES; j++) begin
          // A letter is judged against the left base, a colour against left XOR right.
          key = (f == FUNC_LETTER) ? 2'(j >> 2) : 2'((j >> 2) ^ j);
          emission_acc[j] = sat_add(emission_acc[j], metric_t'((key == sym) ? mc : xc));
        end
      end
      FUNC_CONTIG: begin
        for (int j = 0; j < NSTATES; j++) begin
          emission_acc[j] = '0;
          path_acc[j] = '0;
        end
        column_is_first = 1'b1;
      end
      default: begin
        for (int j = 0; j < NSTATES; j++) begin
          if (column_is_first) begin
            newm[j] = emission_acc[j];
          end else begin
            // Predecessors of j are the states whose right base is j's left
            // base; scanning upward with a strict compare keeps the lowest on ties.
            pick = (j >> 2) & 3;
            for (int k = pick + 4; k < NSTATES; k += 4) begin
              if (path_acc[k] < path_acc[pick]) pick = k;
            end
            newm[j] = sat_add(emission_acc[j], path_acc[pick]);
            bp[4*j +: 4] = 4'(pick);
          end
        end
        best = 0;
        for (int j = 1; j < NSTATES; j++) begin
          if (newm[j] < newm[best]) best = j;
        end
        wide = 64'(newm[best]);
        res.back_pointers = bp;
        res.best_state    = 4'(best);
        res.best_metric   = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
        res.first_column  = column_is_first;
        if (res.best_metric == '1) saturated_columns++;
        expected_columns.push_back(res);
        for (int j = 0; j < NSTATES; j++) begin
          path_acc[j] = newm[j];
          emission_acc[j] = '0;
        end
        column_is_first = 1'b0;
      end
    endcase
  endtask

  // Sends one beat, with an occasional random gap before it, and advances the
  // predictor at the edge where the beat is taken. It returns right after that
  // edge with valid still high, so back-to-back beats keep valid up.
  task automatic send_beat(func_t f, logic [1:0] sym, logic [15:0] mc, logic [15:0] xc);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.func          <= f;
    in_bus.symbol        <= sym;
    in_bus.match_cost    <= mc;
    in_bus.mismatch_cost <= xc;
    do @(posedge clk); while (!in_bus.ready);
    predict_beat(f, sym, mc, xc);
    beats_sent++;
  endtask

  // Costs are drawn three ways: tiny values so that metrics tie often, the
  // extremes of the range, and anything at all.
  function automatic logic [15:0] pick_cost();
    int mode;
    mode = $urandom_range(0, 5);
    if (mode < 2) return 16'($urandom_range(0, 3));
    if (mode == 2) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // Right after reset: an empty first column, every letter at the cost extremes
  // and every colour, a second column with backpointers, and a contig restart
  // both with pending observations and followed directly by a close.
  task automatic test_directed_columns();
    send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    for (int s = 0; s < 4; s++) send_beat(FUNC_LETTER, 2'(s), 16'h0000, 16'hFFFF);
    send_beat(FUNC_CLOSE, 2'd3, 16'hFFFF, 16'h0000);
    for (int s = 0; s < 4; s++) send_beat(FUNC_COLOUR, 2'(s), 16'hFFFF, 16'h0001);
    send_beat(FUNC_LETTER, 2'd2, 16'h0100, 16'h0855);
    send_beat(FUNC_CLOSE, 2'd1, 16'h1234, 16'h5678);
    send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    send_beat(FUNC_LETTER, 2'd1, 16'hFFFF, 16'hFFFF);
    send_beat(FUNC_CONTIG, 2'd2, 16'hAAAA, 16'h5555);
    send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    send_beat(FUNC_COLOUR, 2'd3, 16'h5555, 16'hAAAA);
    send_beat(FUNC_LETTER, 2'd0, 16'h00FF, 16'hFF00);
    send_beat(FUNC_CLOSE, 2'd2, 16'h0000, 16'h0000);
    send_beat(FUNC_CONTIG, 2'd0, 16'h0000, 16'h0000);
  endtask

  // Equal or near-equal costs make many predecessors tie, which checks that
  // the lowest index wins both in the compare-select and the best-state search.
  task automatic test_tie_breaks();
    send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    for (int c = 0; c < 6; c++) begin
      send_beat(FUNC_LETTER, 2'($urandom_range(0, 3)), 16'h0001, 16'h0001);
      send_beat(FUNC_COLOUR, 2'($urandom_range(0, 3)), 16'h0000, 16'h0001);
      send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    end
    send_beat(FUNC_CONTIG, 2'd1, 16'h0000, 16'h0000);
  endtask

  // One long column of costly observations builds large emission sums, and
  // the columns that follow carry those large metrics through the
  // compare-select and the best-state search.
  task automatic test_large_metrics();
    for (int n = 0; n < LONG_OBS; n++) begin
      send_beat(func_t'((n % 3 == 0) ? FUNC_COLOUR : FUNC_LETTER), 2'(n),
                16'hFFFF, 16'($urandom));
    end
    send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    send_beat(FUNC_LETTER, 2'd3, 16'h0001, 16'hFFFF);
    send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    send_beat(FUNC_CLOSE, 2'd0, 16'h0000, 16'h0000);
    send_beat(FUNC_CONTIG, 2'd0, 16'h0000, 16'h0000);
  endtask

  // Mostly well-formed columns of a few observations ending in a close, with
  // occasional contig restarts and stray beats of any kind mixed in. Idling
  // stops for the last part so that back-to-back traffic is covered too.
  task automatic test_random_columns();
    int start;
    int r;
    int n_obs;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      idle_enable = (beats_sent - start) < (RANDOM_BEATS * 85 / 100);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_beat(FUNC_CONTIG, 2'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 10) begin
        send_beat(func_t'($urandom_range(0, 3)), 2'($urandom), pick_cost(), pick_cost());
      end else begin
        n_obs = $urandom_range(0, 6);
        for (int i = 0; i < n_obs; i++) begin
          send_beat(func_t'(($urandom_range(0, 1) != 0) ? FUNC_COLOUR : FUNC_LETTER),
                    2'($urandom), pick_cost(), pick_cost());
        end
        send_beat(FUNC_CLOSE, 2'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // Result side: ready drops in random bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Each result beat is compared with the oldest expected column.
  always @(posedge clk) begin
    column_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_columns.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: bp=%h best=%0d metric=%h first=%b",
                   out_bus.back_pointers, out_bus.best_state, out_bus.best_metric,
                   out_bus.first_column);
        end
      end else begin
        want = expected_columns.pop_front();
        if (out_bus.back_pointers !== want.back_pointers ||
            out_bus.best_state !== want.best_state ||
            out_bus.best_metric !== want.best_metric ||
            out_bus.first_column !== want.first_column) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("column %0d mismatch: expected bp=%h best=%0d metric=%h first=%b",
                     columns_checked, want.back_pointers, want.best_state,
                     want.best_metric, want.first_column);
            $display("column %0d mismatch: got      bp=%h best=%0d metric=%h first=%b",
                     columns_checked, out_bus.back_pointers, out_bus.best_state,
                     out_bus.best_metric, out_bus.first_column);
          end
        end
        columns_checked++;
      end
    end
  end

  // Hang detection: any beat on either channel restarts the count.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("no beat accepted for %0d cycles, %0d columns still expected",
                 quiet_cycles, expected_columns.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_bus.valid         = 1'b0;
    in_bus.func          = FUNC_LETTER;
    in_bus.symbol        = '0;
    in_bus.match_cost    = '0;
    in_bus.mismatch_cost = '0;
    rst_n                = 1'b0;
    beats_sent           = 0;
    columns_checked      = 0;
    mismatch_count       = 0;
    saturated_columns    = 0;
    idle_enable          = 1'b1;
    for (int j = 0; j < NSTATES; j++) begin
      emission_acc[j] = '0;
      path_acc[j] = '0;
    end
    column_is_first = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_columns();
    test_tie_breaks();
    test_large_metrics();
    test_random_columns();

    // Drain: wait for every expected column, then let the two-stage pipeline run
    // on so that any stray result beat would be caught.
    in_bus.valid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_columns.size() != 0) mismatch_count++;
    $display("Sent %0d beats of observations, closes and contig starts; checked %0d columns.",
             beats_sent, columns_checked);
    $display("Covered first and empty columns, ties, restarts, a long column; %0d at ceiling.",
             saturated_columns);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatching columns", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
